@@ hw/rtl/bcv_pkg.sv @@
// Package for the bounding-box centering block.
// Holds the coordinate type, the item structs and the saturation helper.
// No dependencies.
`default_nettype none

package bcv_pkg;

   localparam int NumAxes = 3;
   localparam int CoordWidth = 32;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [CoordWidth:0]   wide_type;

   localparam coord_type COORD_MAX = {1'b0, {(CoordWidth-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(CoordWidth-1){1'b0}}};

   // One vertex as it enters the block
   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
      logic               final_vertex;
   } req_item_type;

   // One centered vertex as it leaves the block
   typedef struct packed {
      logic signed [31:0] centered_x;
      logic signed [31:0] centered_y;
      logic signed [31:0] centered_z;
      logic               last_out;
      logic               overflowed;
   } rsp_item_type;

   // Clamp a 33-bit signed value to the coordinate range
   function automatic coord_type sat_coord(wide_type value);
      coord_type result;
      if (value[CoordWidth] != value[CoordWidth-1]) begin
         result = value[CoordWidth] ? COORD_MIN : COORD_MAX;
      end else begin
         result = value[CoordWidth-1:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bcv_if.sv @@
// Valid/ready channel interfaces for the bounding-box centering block.
// Depends on bcv_pkg for the item structs.
`default_nettype none

interface bcv_req_if
   import bcv_pkg::*;
   ();
   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bcv_rsp_if
   import bcv_pkg::*;
   ();
   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bbox_center_vertices_top.sv @@
// Load: one vertex item per cycle; each is written to the vertex memory at once
//   while there is room, else dropped and flagged. Emit: after the final item the
//   midpoint is formed with the first memory read, then the output is loaded; then
//   one per cycle while not stalled. Input is held off until the last result loads.
// Reset clears the bounds, the vertex count and the drop flag; memory is not cleared.
// Depends on bcv_pkg and bcv_if.
`default_nettype none

module bbox_center_vertices_top
   import bcv_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  wire         clock,
   input  wire         reset,
   bcv_req_if.sink     req_ch,
   bcv_rsp_if.source   rsp_ch
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [CW-1:0] CAP = CW'(MAX_VERTICES);
   localparam int MW = NumAxes * CoordWidth;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_MID,
      ST_DRIVE
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] count_ff;
   logic          drop_ff;
   logic [AW-1:0] rd_ptr_ff;
   logic [AW-1:0] last_idx_ff;
   coord_type     min_ff [NumAxes];
   coord_type     max_ff [NumAxes];
   coord_type     mid_ff [NumAxes];
   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;

   logic [MW-1:0] mem [MAX_VERTICES];
   logic [MW-1:0] rd_data_ff;

   logic          req_fire;
   logic          has_room;
   logic          store_en;
   logic          out_free;
   logic          emit_en;
   logic          at_last;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [CW-1:0] last_cnt;
   coord_type     in_coord [NumAxes];
   coord_type     rd_coord [NumAxes];
   coord_type     centered [NumAxes];
   wide_type      mid_sum  [NumAxes];
   wide_type      mid_half [NumAxes];

   // Handshake and sequencing controls
   always_comb begin
      req_fire = req_ch.valid && req_ch.ready;
      has_room = count_ff < CAP;
      store_en = req_fire && has_room;
      out_free = !rsp_valid_ff || rsp_ch.ready;
      emit_en  = (state_ff == ST_DRIVE) && out_free;
      at_last  = rd_ptr_ff == last_idx_ff;
      rd_en    = (state_ff == ST_MID) || (emit_en && !at_last);
      rd_addr  = (state_ff == ST_MID) ? '0 : rd_ptr_ff + AW'(1);
      wr_addr  = count_ff[AW-1:0];
      last_cnt = has_room ? count_ff : count_ff - CW'(1);
   end

   // Split coordinates per axis; form midpoints and centered values
   always_comb begin
      in_coord[0] = req_ch.payload.vertex_x;
      in_coord[1] = req_ch.payload.vertex_y;
      in_coord[2] = req_ch.payload.vertex_z;
      for (int a = 0; a < NumAxes; a++) begin
         rd_coord[a] = rd_data_ff[a*CoordWidth +: CoordWidth];
         mid_sum[a]  = wide_type'(min_ff[a]) + wide_type'(max_ff[a]);
         mid_half[a] = mid_sum[a] >>> 1;
         centered[a] = sat_coord(wide_type'(rd_coord[a]) - wide_type'(mid_ff[a]));
      end
   end

   assign req_ch.ready   = (state_ff == ST_LOAD);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_item_ff;

   // Vertex memory: write on store, registered read
   always_ff @(posedge clock) begin
      if (store_en) begin
         mem[wr_addr] <= {in_coord[2], in_coord[1], in_coord[0]};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Sequencer, bounds and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < NumAxes; a++) begin
            min_ff[a] <= COORD_MAX;
            max_ff[a] <= COORD_MIN;
         end
      end else begin
         // drop the output once taken unless a new one loads below
         if (rsp_ch.ready && !emit_en) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  if (has_room) begin
                     count_ff <= count_ff + CW'(1);
                     for (int a = 0; a < NumAxes; a++) begin
                        if (in_coord[a] < min_ff[a]) min_ff[a] <= in_coord[a];
                        if (in_coord[a] > max_ff[a]) max_ff[a] <= in_coord[a];
                     end
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (req_ch.payload.final_vertex) begin
                     last_idx_ff <= last_cnt[AW-1:0];
                     state_ff    <= ST_MID;
                  end
               end
            end
            ST_MID: begin
               for (int a = 0; a < NumAxes; a++) begin
                  mid_ff[a] <= mid_half[a][CoordWidth-1:0];
               end
               rd_ptr_ff <= '0;
               state_ff  <= ST_DRIVE;
            end
            ST_DRIVE: begin
               if (emit_en) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_item_ff.centered_x  <= centered[0];
                  rsp_item_ff.centered_y  <= centered[1];
                  rsp_item_ff.centered_z  <= centered[2];
                  rsp_item_ff.last_out    <= at_last;
                  rsp_item_ff.overflowed  <= drop_ff;
                  if (at_last) begin
                     // run done: clear bounds for the next mesh
                     count_ff <= '0;
                     drop_ff  <= 1'b0;
                     for (int a = 0; a < NumAxes; a++) begin
                        min_ff[a] <= COORD_MAX;
                        max_ff[a] <= COORD_MIN;
                     end
                     state_ff <= ST_LOAD;
                  end else begin
                     rd_ptr_ff <= rd_ptr_ff + AW'(1);
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   // Checks
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP)
      else $error("vertex count above capacity");

   a_final_stops_input: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.payload.final_vertex) |=> !req_ch.ready)
      else $error("input taken right after the final item");

   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (emit_en && at_last) |=> (count_ff == '0) && !drop_ff && req_ch.ready)
      else $error("run state not cleared after last result");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRIVE) |-> (rd_ptr_ff <= last_idx_ff))
      else $error("read pointer past last stored vertex");

endmodule

`default_nettype wire

@@ tb/bbox_center_vertices_top_test.sv @@
// Self-checking testbench for the bounding-box centering block.
// Streams meshes, predicts every centered vertex and checks each result.
// Depends on bcv_pkg, bcv_if and bbox_center_vertices_top.
`default_nettype none

module bbox_center_vertices_top_test;
   import bcv_pkg::*;

   localparam int StoreDepth    = 64;
   localparam int RandomItems   = 20;
   localparam int IdleLimit     = 2000;
   localparam int HoldoffCycles = 200;
   localparam int ReportLimit   = 10;

   logic clock;
   logic reset;

   bcv_req_if req_bus ();
   bcv_rsp_if rsp_bus ();

   bbox_center_vertices_top #(
      .MAX_VERTICES(StoreDepth)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Free-running clock, period 10
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idling controls shared by the test tasks and the receiver
   bit sender_gaps_on;
   bit sink_stalls_on;
   int holdoff_request;

   // Predictor state: stored mesh, per-axis bounds, drop flag
   coord_type    mesh_store [StoreDepth][NumAxes];
   coord_type    lo_bound [NumAxes];
   coord_type    hi_bound [NumAxes];
   int           stored_count;
   bit           dropped;
   rsp_item_type centered_q [$];

   int           mismatch_count;
   int           results_seen;
   int           idle_cycles;
   rsp_item_type want;
   rsp_item_type got;

   // Return bounds, count and drop flag to their empty-mesh values
   function automatic void clear_bounds();
      for (int a = 0; a < NumAxes; a++) begin
         lo_bound[a] = COORD_MAX;
         hi_bound[a] = COORD_MIN;
      end
      stored_count = 0;
      dropped      = 1'b0;
   endfunction

   function automatic coord_type clamp_coord(longint value);
      coord_type result;
      if (value > longint'(COORD_MAX)) begin
         result = COORD_MAX;
      end else if (value < longint'(COORD_MIN)) begin
         result = COORD_MIN;
      end else begin
         result = coord_type'(value);
      end
      return result;
   endfunction

   // Take in one accepted vertex; on the final one queue the centered mesh
   function automatic void absorb_vertex(req_item_type item);
      coord_type    axis_val [NumAxes];
      longint       midpoint [NumAxes];
      rsp_item_type centered;
      axis_val[0] = item.vertex_x;
      axis_val[1] = item.vertex_y;
      axis_val[2] = item.vertex_z;
      if (stored_count < StoreDepth) begin
         for (int a = 0; a < NumAxes; a++) begin
            mesh_store[stored_count][a] = axis_val[a];
            if (axis_val[a] < lo_bound[a]) lo_bound[a] = axis_val[a];
            if (axis_val[a] > hi_bound[a]) hi_bound[a] = axis_val[a];
         end
         stored_count++;
      end else begin
         dropped = 1'b1;
      end
      if (item.final_vertex) begin
         // Floor of the 33-bit sum halved
         for (int a = 0; a < NumAxes; a++) begin
            midpoint[a] = (longint'(lo_bound[a]) + longint'(hi_bound[a])) >>> 1;
         end
         for (int i = 0; i < stored_count; i++) begin
            centered.centered_x = clamp_coord(longint'(mesh_store[i][0]) - midpoint[0]);
            centered.centered_y = clamp_coord(longint'(mesh_store[i][1]) - midpoint[1]);
            centered.centered_z = clamp_coord(longint'(mesh_store[i][2]) - midpoint[2]);
            centered.last_out   = (i == stored_count - 1);
            centered.overflowed = dropped;
            centered_q = {centered_q, centered};
         end
         clear_bounds();
      end
   endfunction

   // Mix of extremes, near-extremes, small values and full-range values
   function automatic coord_type pick_coord();
      coord_type value;
      case ($urandom_range(0, 5))
         0: value = COORD_MAX;
         1: value = COORD_MIN;
         2: value = COORD_MAX - coord_type'($urandom_range(0, 3));
         3: value = COORD_MIN + coord_type'($urandom_range(0, 3));
         4: value = coord_type'(int'($urandom_range(0, 131072)) - 65536);
         default: value = coord_type'($urandom);
      endcase
      return value;
   endfunction

   task automatic note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
         $display("ERROR: %s", msg);
      end
   endtask

   // Offer one vertex and hold it until accepted; valid stays high on return
   task automatic send_vertex(coord_type x, coord_type y, coord_type z, bit fin);
      req_item_type item;
      item.vertex_x     = x;
      item.vertex_y     = y;
      item.vertex_z     = z;
      item.final_vertex = fin;
      if (sender_gaps_on && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= item;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      absorb_vertex(item);
   endtask

   task automatic send_mesh(int count);
      for (int i = 0; i < count; i++) begin
         send_vertex(pick_coord(), pick_coord(), pick_coord(), i == count - 1);
      end
   endtask

   // Drop valid and wait for every queued result
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (centered_q.size() != 0) @(posedge clock);
   endtask

   // One-vertex meshes: each centers to zero
   task automatic test_single_vertex();
      send_vertex(COORD_MAX, COORD_MIN, '0, 1'b1);
      send_vertex('0, '0, '0, 1'b1);
      send_vertex(COORD_MIN, coord_type'(-1), COORD_MAX, 1'b1);
      drain_results();
   endtask

   // Full-range bounds on some axes: midpoint -1 there, top vertex saturates
   task automatic test_extreme_bounds();
      send_vertex(COORD_MIN, COORD_MAX, coord_type'(32'h7fff_0000), 1'b0);
      send_vertex(COORD_MAX, COORD_MIN, coord_type'(-65536), 1'b1);
      send_vertex(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX - 1, COORD_MIN, COORD_MIN + 1, 1'b1);
      drain_results();
   endtask

   // Odd sums round toward minus infinity, both signs
   task automatic test_floor_midpoint();
      send_vertex(coord_type'(-3), coord_type'(5), '0, 1'b0);
      send_vertex('0, coord_type'(-2), coord_type'(7), 1'b0);
      send_vertex(coord_type'(-1), coord_type'(1), coord_type'(3), 1'b1);
      send_vertex(coord_type'(-7), coord_type'(-5), coord_type'(-65537), 1'b0);
      send_vertex(coord_type'(-8), coord_type'(-6), coord_type'(-2), 1'b1);
      drain_results();
   endtask

   // Fill the store, then drop one vertex and the final one
   task automatic test_store_full();
      send_mesh(StoreDepth + 2);
      drain_results();
   endtask

   // Hold the receiver off while further meshes are offered behind the first
   task automatic test_output_backpressure();
      holdoff_request = HoldoffCycles;
      send_mesh(8);
      send_mesh(6);
      send_mesh(1);
      drain_results();
   endtask

   // Random mesh sizes and content with random idling on both sides
   task automatic test_random_meshes();
      int sent;
      int count;
      sent = 0;
      while (sent < RandomItems) begin
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         sink_stalls_on = ($urandom_range(0, 3) != 0);
         count = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
         send_mesh(count);
         sent += count;
      end
      drain_results();
   endtask

   // Back-to-back meshes with no idling at all
   task automatic test_steady_stream();
      sender_gaps_on = 1'b0;
      sink_stalls_on = 1'b0;
      for (int m = 0; m < 4; m++) begin
         send_mesh($urandom_range(1, 10));
      end
      drain_results();
   endtask

   // Receiver: random stall bursts and a long requested hold-off
   initial begin
      int holdoff_left;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request > 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
            rsp_bus.ready <= 1'b0;
            while (holdoff_left > 0) begin
               @(posedge clock);
               holdoff_left--;
            end
            rsp_bus.ready <= 1'b1;
         end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = rsp_bus.payload;
         if (centered_q.size() == 0) begin
            note_failure($sformatf("result %0d arrived with none expected: %h %h %h %b %b",
               results_seen, got.centered_x, got.centered_y, got.centered_z,
               got.last_out, got.overflowed));
         end else begin
            want = centered_q.pop_front();
            if (got.centered_x !== want.centered_x || got.centered_y !== want.centered_y ||
                got.centered_z !== want.centered_z || got.last_out !== want.last_out ||
                got.overflowed !== want.overflowed) begin
               note_failure($sformatf(
                  "result %0d: expected %h %h %h %b %b, got %h %h %h %b %b",
                  results_seen, want.centered_x, want.centered_y, want.centered_z,
                  want.last_out, want.overflowed, got.centered_x, got.centered_y,
                  got.centered_z, got.last_out, got.overflowed));
            end
         end
         results_seen++;
      end
   end

   // Watchdog: end the run after too many cycles with no item moving
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Reset, run the tests in turn, then report
   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      reset           <= 1'b1;
      idle_cycles     = 0;
      mismatch_count  = 0;
      results_seen    = 0;
      sender_gaps_on  = 1'b0;
      sink_stalls_on  = 1'b0;
      holdoff_request = 0;
      clear_bounds();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_vertex();
      test_extreme_bounds();
      test_floor_midpoint();
      sender_gaps_on = 1'b1;
      sink_stalls_on = 1'b1;
      test_store_full();
      test_output_backpressure();
      test_random_meshes();
      test_steady_stream();

      // Let any stray result show up before the verdict
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && centered_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/bcv_pkg.sv
hw/rtl/bcv_if.sv
hw/rtl/bbox_center_vertices_top.sv
tb/bbox_center_vertices_top_test.sv
